>>> hw/rtl/ecpa_pkg.sv
// Shared types, codes and fixed-point helpers of the element curl-pressure assembly.
// No dependencies; every other file in hw/rtl refers to this package by scoped name.
package ecpa_pkg;

   // Item kinds
   localparam logic [2:0] KIND_NODE      = 3'd0;
   localparam logic [2:0] KIND_TEST_SHP  = 3'd1;
   localparam logic [2:0] KIND_TRIAL_CRL = 3'd2;
   localparam logic [2:0] KIND_TEST_DOF  = 3'd3;
   localparam logic [2:0] KIND_TRIAL_DOF = 3'd4;
   localparam logic [2:0] KIND_COMPUTE   = 3'd5;

   localparam int FIELD_DOF_W = 20;
   localparam int NODE_CTR_W  = 6;
   localparam int FUNC_CTR_W  = 3;
   localparam logic [4:0] NODE_COUNT_RST = 5'd16;

   typedef struct packed {
      logic [2:0]               kind;
      logic [3:0]               node_index;
      logic [2:0]               func_index;
      logic signed [31:0]       jacobian;
      logic signed [31:0]       node_weight;
      logic signed [31:0]       coeff_value;
      logic signed [31:0]       shape_value;
      logic [FIELD_DOF_W-1:0]   dof_number;
      logic                     area_positive;
      logic [3:0]               test_count;
      logic [3:0]               trial_count;
   } req_item_type;

   typedef struct packed {
      logic [FIELD_DOF_W-1:0]   row_dof;
      logic [FIELD_DOF_W-1:0]   col_dof;
      logic signed [63:0]       entry_value;
      logic                     last;
      logic                     skipped;
   } rsp_item_type;

   // Controller to datapath commands
   typedef struct packed {
      logic                  wr_test;
      logic                  wr_trial;
      logic                  wr_test_dof;
      logic                  wr_trial_dof;
      logic                  nf_latch;
      logic                  nf_mode;
      logic                  mul_first;
      logic                  mul_second;
      logic                  nf_write;
      logic                  rd;
      logic                  acc_clr;
      logic                  acc_en;
      logic                  skip;
      logic                  last;
      logic [FUNC_CTR_W-1:0] test_idx;
      logic [FUNC_CTR_W-1:0] trial_idx;
      logic [NODE_CTR_W-1:0] node_idx;
   } cmd_type;

   // Floor a Q32.32 product to Q16.16 and saturate to 32 bits
   function automatic logic signed [31:0] sat_q16(input logic signed [63:0] p);
      logic signed [47:0] s;
      s = 48'(p >>> 16);
      if (s > 48'sd2147483647)
         return 32'sh7fffffff;
      else if (s < -48'sd2147483648)
         return 32'sh80000000;
      else
         return s[31:0];
   endfunction

   // Signed 64-bit add with saturation
   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63])
         return s[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
      else
         return s[63:0];
   endfunction

endpackage

>>> hw/rtl/ecpa_channels.sv
// Handshake channel interfaces: request, response and register write.
// Depends on ecpa_pkg for the payload types.
interface ecpa_req_if;
   logic                  valid;
   logic                  ready;
   ecpa_pkg::req_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ecpa_rsp_if;
   logic                  valid;
   logic                  ready;
   ecpa_pkg::rsp_item_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ecpa_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/element_curl_pressure_assembly.sv
// Element curl-pressure assembly top level: channels, sequencer and datapath.
// Depends on ecpa_pkg, ecpa_channels, ecpa_ctrl and ecpa_datapath.
//
// Load transactions (node data, test shapes, trial curls, dof numbers) fill the
// per-element stores; a compute transaction then returns one response per
// (test, trial) pair, test outer and trial inner, with last set on the final
// one, or a single skipped response when the element has no positive area.
// Dof, shape and curl loads are written as they are accepted; a node-data load
// then steps through two chained multiplies on the shared multipliers and a
// store write. A compute transaction clears the accumulator for each pair, then
// each node steps through store read, two multiplies and the accumulate on one
// shared multiplier pair, and each response waits until the channel takes it.
// Entries of stores never loaded read as undefined.
module element_curl_pressure_assembly #(
   parameter int MAX_NODES       = 16,
   parameter int MAX_TEST_FUNCS  = 8,
   parameter int MAX_TRIAL_FUNCS = 8,
   parameter int DOF_BITS        = 20
) (
   input logic        clock,
   input logic        reset,
   ecpa_req_if.sink   req_chan,
   ecpa_rsp_if.source rsp_chan,
   ecpa_csr_if.sink   csr_chan
);

   ecpa_pkg::cmd_type cmd;

   assign csr_chan.ready = 1'b1;

   ecpa_ctrl #(
      .MAX_NODES       (MAX_NODES),
      .MAX_TEST_FUNCS  (MAX_TEST_FUNCS),
      .MAX_TRIAL_FUNCS (MAX_TRIAL_FUNCS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_data  (req_chan.data),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .csr_valid (csr_chan.valid),
      .csr_data  (csr_chan.data),
      .cmd       (cmd)
   );

   ecpa_datapath #(
      .MAX_NODES       (MAX_NODES),
      .MAX_TEST_FUNCS  (MAX_TEST_FUNCS),
      .MAX_TRIAL_FUNCS (MAX_TRIAL_FUNCS),
      .DOF_BITS        (DOF_BITS)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_chan.data),
      .cmd      (cmd),
      .rsp_data (rsp_chan.data)
   );

   // Never take a transaction while a response is pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request accepted during response");

   // Return to idle after the final response of an element
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.data.last |=> req_chan.ready)
      else $error("not idle after last response");

   // A skipped element gives a single, zero, final response
   a_skip_form: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.data.skipped |->
      rsp_chan.data.last && rsp_chan.data.entry_value == 64'sd0)
      else $error("malformed skipped response");

endmodule

>>> hw/rtl/ecpa_ctrl.sv
// Sequencer of the assembly: state machine, loop counters and node count register.
// Depends on ecpa_pkg; drives the command struct of ecpa_datapath.
module ecpa_ctrl #(
   parameter int MAX_NODES       = 16,
   parameter int MAX_TEST_FUNCS  = 8,
   parameter int MAX_TRIAL_FUNCS = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  ecpa_pkg::req_item_type req_data,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   csr_valid,
   input  logic [4:0]             csr_data,
   output ecpa_pkg::cmd_type      cmd
);

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_NF1  = 10'b0000000010,
      S_NF2  = 10'b0000000100,
      S_NF3  = 10'b0000001000,
      S_PAIR = 10'b0000010000,
      S_RD   = 10'b0000100000,
      S_M1   = 10'b0001000000,
      S_M2   = 10'b0010000000,
      S_ACC  = 10'b0100000000,
      S_EMIT = 10'b1000000000
   } state_type;

   localparam int NW = ecpa_pkg::NODE_CTR_W;
   localparam int FW = ecpa_pkg::FUNC_CTR_W;

   state_type       state_ff, state_in;
   logic [4:0]      node_count_ff, node_count_in;
   logic [NW-1:0]   n_ff, n_in;
   logic [FW-1:0]   i_ff, i_in, j_ff, j_in;
   logic [3:0]      nt_ff, nt_in, nv_ff, nv_in;
   logic            skip_ff, skip_in;
   logic [NW-1:0]   nn;
   logic            accept, node_ok, func_test_ok, func_trial_ok, last_pair;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign accept    = req_valid && req_ready;

   assign nn = (32'(node_count_ff) > MAX_NODES) ? NW'(MAX_NODES) : NW'(node_count_ff);
   assign node_ok       = 32'(req_data.node_index) < MAX_NODES;
   assign func_test_ok  = 32'(req_data.func_index) < MAX_TEST_FUNCS;
   assign func_trial_ok = 32'(req_data.func_index) < MAX_TRIAL_FUNCS;
   assign last_pair = (i_ff == FW'(nt_ff - 4'd1)) && (j_ff == FW'(nv_ff - 4'd1));

   // Next state and counters
   always_comb begin
      state_in      = state_ff;
      node_count_in = csr_valid ? csr_data : node_count_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      nt_in         = nt_ff;
      nv_in         = nv_ff;
      skip_in       = skip_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_data.kind == ecpa_pkg::KIND_NODE && node_ok) begin
               state_in = S_NF1;
            end else if (accept && req_data.kind == ecpa_pkg::KIND_COMPUTE) begin
               i_in = '0;
               j_in = '0;
               nt_in = (req_data.test_count == 4'd0) ? 4'd1 :
                       (32'(req_data.test_count) > MAX_TEST_FUNCS) ?
                       4'(MAX_TEST_FUNCS) : req_data.test_count;
               nv_in = (req_data.trial_count == 4'd0) ? 4'd1 :
                       (32'(req_data.trial_count) > MAX_TRIAL_FUNCS) ?
                       4'(MAX_TRIAL_FUNCS) : req_data.trial_count;
               skip_in  = !req_data.area_positive;
               state_in = req_data.area_positive ? S_PAIR : S_EMIT;
            end
         end
         S_NF1: state_in = S_NF2;
         S_NF2: state_in = S_NF3;
         S_NF3: state_in = S_IDLE;
         S_PAIR: begin
            n_in     = '0;
            state_in = (nn == '0) ? S_EMIT : S_RD;
         end
         S_RD:  state_in = S_M1;
         S_M1:  state_in = S_M2;
         S_M2:  state_in = S_ACC;
         S_ACC: begin
            if (n_ff == nn - NW'(1)) begin
               state_in = S_EMIT;
            end else begin
               n_in     = n_ff + NW'(1);
               state_in = S_RD;
            end
         end
         S_EMIT: begin
            if (rsp_ready) begin
               if (skip_ff || last_pair) begin
                  skip_in  = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_PAIR;
                  if (j_ff == FW'(nv_ff - 4'd1)) begin
                     j_in = '0;
                     i_in = i_ff + FW'(1);
                  end else begin
                     j_in = j_ff + FW'(1);
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= ecpa_pkg::NODE_COUNT_RST;
         skip_ff       <= 1'b0;
         n_ff          <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         nt_ff         <= 4'd1;
         nv_ff         <= 4'd1;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         skip_ff       <= skip_in;
         n_ff          <= n_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         nt_ff         <= nt_in;
         nv_ff         <= nv_in;
      end
   end

   // Decode commands
   always_comb begin
      cmd              = '0;
      cmd.wr_test      = accept && req_data.kind == ecpa_pkg::KIND_TEST_SHP &&
                         node_ok && func_test_ok;
      cmd.wr_trial     = accept && req_data.kind == ecpa_pkg::KIND_TRIAL_CRL &&
                         node_ok && func_trial_ok;
      cmd.wr_test_dof  = accept && req_data.kind == ecpa_pkg::KIND_TEST_DOF && func_test_ok;
      cmd.wr_trial_dof = accept && req_data.kind == ecpa_pkg::KIND_TRIAL_DOF && func_trial_ok;
      cmd.nf_latch     = accept && req_data.kind == ecpa_pkg::KIND_NODE;
      cmd.nf_mode      = (state_ff == S_NF1) || (state_ff == S_NF2);
      cmd.mul_first    = (state_ff == S_NF1) || (state_ff == S_M1);
      cmd.mul_second   = (state_ff == S_NF2) || (state_ff == S_M2);
      cmd.nf_write     = (state_ff == S_NF3);
      cmd.rd           = (state_ff == S_RD);
      cmd.acc_clr      = (state_ff == S_PAIR);
      cmd.acc_en       = (state_ff == S_ACC);
      cmd.skip         = skip_ff;
      cmd.last         = skip_ff || last_pair;
      cmd.test_idx     = i_ff;
      cmd.trial_idx    = j_ff;
      cmd.node_idx     = n_ff;
   end

endmodule

>>> hw/rtl/ecpa_datapath.sv
// Datapath: node, shape, curl and dof stores, shared multipliers and Q32.32 accumulator.
// Depends on ecpa_pkg; steered by the command struct from ecpa_ctrl.
module ecpa_datapath #(
   parameter int MAX_NODES       = 16,
   parameter int MAX_TEST_FUNCS  = 8,
   parameter int MAX_TRIAL_FUNCS = 8,
   parameter int DOF_BITS        = 20
) (
   input  logic                   clock,
   input  ecpa_pkg::req_item_type req_data,
   input  ecpa_pkg::cmd_type      cmd,
   output ecpa_pkg::rsp_item_type rsp_data
);

   localparam int NW   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int TD   = MAX_TEST_FUNCS * MAX_NODES;
   localparam int VD   = MAX_TRIAL_FUNCS * MAX_NODES;
   localparam int TAW  = (TD > 1) ? $clog2(TD) : 1;
   localparam int VAW  = (VD > 1) ? $clog2(VD) : 1;
   localparam int TFW  = (MAX_TEST_FUNCS > 1) ? $clog2(MAX_TEST_FUNCS) : 1;
   localparam int VFW  = (MAX_TRIAL_FUNCS > 1) ? $clog2(MAX_TRIAL_FUNCS) : 1;
   localparam int DW   = (DOF_BITS < ecpa_pkg::FIELD_DOF_W) ? DOF_BITS : ecpa_pkg::FIELD_DOF_W;

   logic signed [31:0] node_factor [MAX_NODES];
   logic               node_active [MAX_NODES];
   logic signed [31:0] test_shape_store [TD];
   logic signed [31:0] trial_curl_store [VD];
   logic [DW-1:0]      test_dof_store [MAX_TEST_FUNCS];
   logic [DW-1:0]      trial_dof_store [MAX_TRIAL_FUNCS];

   logic signed [31:0] jac_ff, wgt_ff, cof_ff;
   logic [NW-1:0]      nf_node_ff;
   logic signed [31:0] fac_rd_ff, shp_rd_ff, crl_rd_ff;
   logic               act_rd_ff;
   logic signed [31:0] mul1_a, mul1_b, mul2_a, mul2_b;
   logic signed [63:0] prod_ff, prod_in, prod2_ff, prod2_in;
   logic signed [63:0] acc_ff, acc_in;
   logic [TAW-1:0]     t_waddr, t_raddr;
   logic [VAW-1:0]     v_waddr, v_raddr;
   logic [NW-1:0]      w_node, r_node;

   assign w_node  = NW'(req_data.node_index);
   assign r_node  = NW'(cmd.node_idx);
   assign t_waddr = TAW'(32'(req_data.func_index) * MAX_NODES + 32'(req_data.node_index));
   assign v_waddr = VAW'(32'(req_data.func_index) * MAX_NODES + 32'(req_data.node_index));
   assign t_raddr = TAW'(32'(cmd.test_idx) * MAX_NODES + 32'(cmd.node_idx));
   assign v_raddr = VAW'(32'(cmd.trial_idx) * MAX_NODES + 32'(cmd.node_idx));

   // Store writes and registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_test) begin
         test_shape_store[t_waddr] <= req_data.shape_value;
      end
      if (cmd.wr_trial) begin
         trial_curl_store[v_waddr] <= req_data.shape_value;
      end
      if (cmd.wr_test_dof) begin
         test_dof_store[TFW'(req_data.func_index)] <= DW'(req_data.dof_number);
      end
      if (cmd.wr_trial_dof) begin
         trial_dof_store[VFW'(req_data.func_index)] <= DW'(req_data.dof_number);
      end
      if (cmd.nf_write) begin
         node_factor[nf_node_ff] <= ecpa_pkg::sat_q16(prod2_ff);
         node_active[nf_node_ff] <= (wgt_ff > 32'sd0);
      end
      if (cmd.rd) begin
         shp_rd_ff <= test_shape_store[t_raddr];
         crl_rd_ff <= trial_curl_store[v_raddr];
         fac_rd_ff <= node_factor[r_node];
         act_rd_ff <= node_active[r_node];
      end
   end

   // Latch node data
   always_ff @(posedge clock) begin
      if (cmd.nf_latch) begin
         jac_ff     <= req_data.jacobian;
         wgt_ff     <= req_data.node_weight;
         cof_ff     <= req_data.coeff_value;
         nf_node_ff <= w_node;
      end
   end

   // Shared 32x32 multipliers, one register after each
   always_comb begin
      mul1_a   = cmd.nf_mode ? jac_ff : fac_rd_ff;
      mul1_b   = cmd.nf_mode ? wgt_ff : shp_rd_ff;
      mul2_a   = ecpa_pkg::sat_q16(prod_ff);
      mul2_b   = cmd.nf_mode ? cof_ff : crl_rd_ff;
      prod_in  = mul1_a * mul1_b;
      prod2_in = mul2_a * mul2_b;
      acc_in   = acc_ff;
      if (cmd.acc_clr)
         acc_in = '0;
      else if (cmd.acc_en && act_rd_ff)
         acc_in = ecpa_pkg::sat_add64(acc_ff, prod2_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_first)
         prod_ff <= prod_in;
      if (cmd.mul_second)
         prod2_ff <= prod2_in;
      acc_ff <= acc_in;
   end

   // Drive result fields
   always_comb begin
      rsp_data.row_dof     = cmd.skip ? '0 :
                             ecpa_pkg::FIELD_DOF_W'(test_dof_store[TFW'(cmd.test_idx)]);
      rsp_data.col_dof     = cmd.skip ? '0 :
                             ecpa_pkg::FIELD_DOF_W'(trial_dof_store[VFW'(cmd.trial_idx)]);
      rsp_data.entry_value = cmd.skip ? '0 : acc_ff;
      rsp_data.last        = cmd.last;
      rsp_data.skipped     = cmd.skip;
   end

endmodule
